[hw/rtl/asset_text_tokenizer_defines.svh]
// Assertion macros for the top-level file, which carries the concurrent checks.
`ifndef ASSET_TEXT_TOKENIZER_DEFINES_SVH
`define ASSET_TEXT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define TAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/tat_pkg.sv]
package tat_pkg;

    localparam int POSITION_BITS = 16;
    localparam int KIND_BITS     = 4;
    localparam int FIELD_BITS    = 16;
    localparam int GROUP_SLOTS   = 3;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_IDENT  = 2'd3
    } tat_mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INVALID = 4'd0,
        KIND_LBRACE  = 4'd1,
        KIND_RBRACE  = 4'd2,
        KIND_LBRACK  = 4'd3,
        KIND_RBRACK  = 4'd4,
        KIND_COLON   = 4'd5,
        KIND_COMMA   = 4'd6,
        KIND_SEMI    = 4'd7,
        KIND_EQUALS  = 4'd8,
        KIND_STRING  = 4'd9,
        KIND_INTEGER = 4'd10,
        KIND_IDENT   = 4'd11,
        KIND_END     = 4'd12
    } tat_kind_t;

    typedef struct packed {
        tat_kind_t             kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
    } token_t;

    // All tokens caused by one accepted item, written to the queue at once.
    typedef struct packed {
        logic                        push;
        logic [1:0]                  count;
        token_t [GROUP_SLOTS-1:0]    tokens;
    } tat_group_t;

    typedef struct packed {
        logic       ready;
        logic [2:0] count;
    } tat_queue_stat_t;

    typedef struct packed {
        tat_mode_t                mode;
        logic [POSITION_BITS-1:0] position;
    } tat_lex_stat_t;

endpackage

[hw/rtl/tat_ifs.sv]
interface tat_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       has_character;
    logic       end_of_source;

    modport source (output valid, character, has_character, end_of_source, input ready);
    modport sink (input valid, character, has_character, end_of_source, output ready);
endinterface

interface tat_token_if import tat_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  token_kind;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] token_length;
    logic                  last_result;

    modport source (output valid, token_kind, token_start, token_length, last_result,
                    input ready);
    modport sink (input valid, token_kind, token_start, token_length, last_result,
                  output ready);
endinterface

[hw/rtl/tat_lexer.sv]
module tat_lexer import tat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    tat_char_if.sink        src,
    input  tat_queue_stat_t qstat,
    output tat_group_t      group,
    output tat_lex_stat_t   lstat
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    tat_mode_t                mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [POSITION_BITS-1:0] pos_adv;
    logic [1:0]               slot;
    logic                     accept;
    logic                     run_idle;
    logic [7:0]               ch;
    tat_kind_t                pkind;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    // Punctuator kind, or KIND_INVALID for any other byte.
    function automatic tat_kind_t punct_kind(input logic [7:0] c);
        tat_kind_t k;
        case (c)
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h3A:   k = KIND_COLON;
            8'h2C:   k = KIND_COMMA;
            8'h3B:   k = KIND_SEMI;
            8'h3D:   k = KIND_EQUALS;
            default: k = KIND_INVALID;
        endcase
        return k;
    endfunction

    // Positions wider than the output field are cut to its width.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+FIELD_BITS-1:0] w;
        w = {{FIELD_BITS{1'b0}}, v};
        return w[FIELD_BITS-1:0];
    endfunction

    assign accept    = src.valid && src.ready;
    assign src.ready = qstat.ready;
    assign ch        = src.character;
    assign pkind     = punct_kind(ch);

    assign lstat.mode     = mode_reg;
    assign lstat.position = pos_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        begin_next   = begin_reg;
        pos_adv      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        pos_next     = pos_reg;
        run_idle     = 1'b0;
        slot         = 2'd0;
        group.tokens = '0;
        group.push   = accept;

        if (src.has_character)
        begin
            pos_next = pos_adv;
            case (mode_reg)
                MODE_STRING:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        group.tokens[slot] = '{KIND_STRING, to_field(begin_reg),
                                               to_field(pos_adv - begin_reg)};
                        slot      = slot + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (!is_numeral(ch))
                    begin
                        group.tokens[slot] = '{KIND_INTEGER, to_field(begin_reg),
                                               to_field(pos_reg - begin_reg)};
                        slot      = slot + 2'd1;
                        mode_next = MODE_IDLE;
                        run_idle  = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (!is_numeral(ch) && !is_letter(ch))
                    begin
                        group.tokens[slot] = '{KIND_IDENT, to_field(begin_reg),
                                               to_field(pos_reg - begin_reg)};
                        slot      = slot + 2'd1;
                        mode_next = MODE_IDLE;
                        run_idle  = 1'b1;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            // A byte that ends a number or an identifier is then taken as in idle.
            if (run_idle && !is_space(ch))
            begin
                if (pkind != KIND_INVALID)
                begin
                    group.tokens[slot] = '{pkind, to_field(pos_reg),
                                           to_field(pos_adv - pos_reg)};
                    slot = slot + 2'd1;
                end
                else if (ch == CH_QUOTE)
                begin
                    mode_next  = MODE_STRING;
                    begin_next = pos_reg;
                end
                else if (is_numeral(ch))
                begin
                    mode_next  = MODE_NUMBER;
                    begin_next = pos_reg;
                end
                else if (is_letter(ch))
                begin
                    mode_next  = MODE_IDENT;
                    begin_next = pos_reg;
                end
                else
                begin
                    group.tokens[slot] = '{KIND_INVALID, to_field(pos_reg),
                                           to_field(pos_adv - pos_reg)};
                    slot = slot + 2'd1;
                end
            end
        end

        if (src.end_of_source)
        begin
            case (mode_next)
                MODE_STRING:
                begin
                    // An unterminated string closes as an invalid token.
                    group.tokens[slot] = '{KIND_INVALID, to_field(begin_next),
                                           to_field(pos_next - begin_next)};
                    slot = slot + 2'd1;
                end
                MODE_NUMBER:
                begin
                    group.tokens[slot] = '{KIND_INTEGER, to_field(begin_next),
                                           to_field(pos_next - begin_next)};
                    slot = slot + 2'd1;
                end
                MODE_IDENT:
                begin
                    group.tokens[slot] = '{KIND_IDENT, to_field(begin_next),
                                           to_field(pos_next - begin_next)};
                    slot = slot + 2'd1;
                end
                default:
                begin
                end
            endcase
            group.tokens[slot] = '{KIND_END, to_field(pos_next), '0};
            slot       = slot + 2'd1;
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            begin_next = '0;
        end

        group.count = slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
        end
    end

endmodule

[hw/rtl/tat_token_queue.sv]
module tat_token_queue import tat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  tat_group_t      group,
    output tat_queue_stat_t qstat,
    tat_token_if.source     tok
);

    localparam int DEPTH = 4;

    typedef struct packed {
        token_t token;
        logic   last;
    } tat_entry_t;

    tat_entry_t q_reg  [DEPTH];
    tat_entry_t q_next [DEPTH];
    logic [2:0] count_reg, count_next;
    logic [1:0] base;
    logic       pop;

    assign pop         = (count_reg != 3'd0) && tok.ready;
    // Room for a full group remains while at most one entry waits.
    assign qstat.ready = count_reg < 3'd2;
    assign qstat.count = count_reg;

    assign tok.valid        = count_reg != 3'd0;
    assign tok.token_kind   = q_reg[0].token.kind;
    assign tok.token_start  = q_reg[0].token.start;
    assign tok.token_length = q_reg[0].token.length;
    assign tok.last_result  = q_reg[0].last;

    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            q_next[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_next[DEPTH-1] = q_reg[DEPTH-1];

        base = count_reg[1:0] - {1'b0, pop};
        if (group.push)
        begin
            for (int k = 0; k < GROUP_SLOTS; k++)
            begin
                if (2'(k) < group.count)
                begin
                    q_next[base + 2'(k)] = '{group.tokens[k],
                                             2'(k) == (group.count - 2'd1)};
                end
            end
        end

        count_next = count_reg - {2'b00, pop} +
                     (group.push ? {1'b0, group.count} : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

[hw/rtl/asset_text_tokenizer.sv]
// Channel  Role    Payload
// src      sink    character, has_character, end_of_source
// tok      source  token_kind, token_start, token_length, last_result
//
// One source byte is taken per cycle while src.ready is high; the scanner state updates in the same cycle.
// An item yields up to three tokens, written together into a four-entry output queue
// that drains one token per cycle while tok.ready is high.
// src.ready is high while at most one token waits in the queue.
// Reset returns the scanner to idle at position 0 and empties the queue.
`include "asset_text_tokenizer_defines.svh"

module asset_text_tokenizer import tat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tat_char_if.sink    src,
    tat_token_if.source tok
);

    tat_group_t      group;
    tat_queue_stat_t qstat;
    tat_lex_stat_t   lstat;

    tat_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .qstat (qstat),
        .group (group),
        .lstat (lstat)
    );

    tat_token_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .group (group),
        .qstat (qstat),
        .tok   (tok)
    );

    // The end of a source always produces at least the end marker.
    `TAT_ASSERT_SAME(a_eos_emits, clk, rst_n, src.valid && src.ready && src.end_of_source, group.count != 2'd0, "end of source produced no token")

    // After the end of a source the scanner restarts at position 0 in idle.
    `TAT_ASSERT_NEXT(a_eos_restart, clk, rst_n, src.valid && src.ready && src.end_of_source, (lstat.position == '0) && (lstat.mode == MODE_IDLE), "scanner not restarted after end of source")

    // A token that is not the last of its group always has its successor queued.
    `TAT_ASSERT_SAME(a_group_whole, clk, rst_n, tok.valid && !tok.last_result, qstat.count >= 3'd2, "partial token group in queue")

    // The queue never overflows its four entries.
    `TAT_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, qstat.count <= 3'd4, "token queue overflow")

endmodule
